FILE: rtl/cmwr_pkg.sv
`timescale 1ns / 1ps

package cmwr_pkg;

  // Received frame checks
  localparam logic [7:0] CMD_WAKE   = 8'h37;
  localparam logic [7:0] CMD_CONFIG = 8'h31;
  localparam logic [7:0] MAGIC_ZERO = 8'h53;
  localparam logic [7:0] MAGIC_ONE  = 8'h38;
  localparam logic [7:0] KEY_OFFSET = 8'h38;
  localparam logic [3:0] LEN_FULL   = 4'd8;

  // Transmitted frame identifiers
  localparam logic [28:0] ID_BOOT  = 29'h0036_0300;
  localparam logic [28:0] ID_PING  = 29'h0030_0300;
  localparam logic [28:0] ID_WAKE3 = 29'h0001_0300;
  localparam logic [28:0] ID_SETUP = 29'h0000_0300;

  // Transmitted frame lengths
  localparam logic [3:0] LEN_NONE  = 4'd0;
  localparam logic [3:0] LEN_WAKE  = 4'd5;
  localparam logic [3:0] LEN_WAKE3 = 4'd7;

  // Payload bytes
  localparam logic [7:0] WAKE_ONE_BYTE   = 8'hE4;
  localparam logic [7:0] WAKE_TWO_BYTE   = 8'h11;
  localparam logic [7:0] WAKE_THREE_BYTE = 8'h0C;
  localparam logic [7:0] SETUP_BYTE      = 8'h0B;
  localparam logic [7:0] SEL_LEN_ONE     = 8'h02;
  localparam logic [7:0] SEL_LEN_TWO     = 8'h03;
  localparam logic [7:0] SEL_LEN_THREE   = 8'h04;
  localparam logic [7:0] SEL_CYC_ONE     = 8'h05;
  localparam logic [7:0] SEL_CYC_TWO     = 8'h06;
  localparam logic [7:0] SEL_CYC_THREE   = 8'h07;

  // Register indexes
  localparam logic [2:0] REG_BUS_ONE_LENGTH   = 3'd0;
  localparam logic [2:0] REG_BUS_TWO_LENGTH   = 3'd1;
  localparam logic [2:0] REG_BUS_THREE_LENGTH = 3'd2;
  localparam logic [2:0] REG_BUS_ONE_CYCLE    = 3'd3;
  localparam logic [2:0] REG_BUS_TWO_CYCLE    = 3'd4;
  localparam logic [2:0] REG_BUS_THREE_CYCLE  = 3'd5;
  localparam logic [2:0] REG_NEEDED_DEVICES   = 3'd6;

  // Result kinds, in emission order
  localparam int NUM_KINDS = 12;
  localparam logic [3:0] K_BOOT      = 4'd0;
  localparam logic [3:0] K_WAKE_ONE  = 4'd1;
  localparam logic [3:0] K_WAKE_TWO  = 4'd2;
  localparam logic [3:0] K_WAKE_THR  = 4'd3;
  localparam logic [3:0] K_PING      = 4'd4;
  localparam logic [3:0] K_LEN_ONE   = 4'd5;
  localparam logic [3:0] K_LEN_TWO   = 4'd6;
  localparam logic [3:0] K_LEN_THR   = 4'd7;
  localparam logic [3:0] K_CYC_ONE   = 4'd8;
  localparam logic [3:0] K_CYC_TWO   = 4'd9;
  localparam logic [3:0] K_CYC_THR   = 4'd10;
  localparam logic [3:0] K_FIN       = 4'd11;

  typedef logic [NUM_KINDS-1:0] kind_mask_t;

  typedef struct packed {
    logic [2:0][7:0] bus_len;
    logic [2:0][9:0] bus_cycle;
    logic [7:0]      needed;
  } cfg_t;

  typedef struct packed {
    logic        present;
    logic [28:0] id;
    logic [3:0]  len;
    logic [63:0] payload;
    logic        fin;
  } frame_t;

  typedef struct packed {
    logic        search;
    logic        store;
    logic [15:0] key;
  } tbl_req_t;

  typedef struct packed {
    logic done;
    logic hit;
  } tbl_rsp_t;

  function automatic logic [63:0] setup_payload(input logic [7:0] h, input logic [7:0] l,
                                                input logic [7:0] sel, input logic [7:0] hi,
                                                input logic [7:0] lo);
    return {MAGIC_ZERO, MAGIC_ONE, h, l, SETUP_BYTE, sel, hi, lo};
  endfunction

  function automatic logic [7:0] cyc_hi(input logic [9:0] cyc);
    return {6'd0, cyc[9:8]};
  endfunction

  // One result of the given kind
  function automatic frame_t build_frame(input logic [3:0] kind, input logic [7:0] h,
                                         input logic [7:0] l, input cfg_t cfg);
    frame_t f;
    f         = '0;
    f.present = 1'b1;
    case (kind)
      K_BOOT: begin
        f.id = ID_BOOT;
      end
      K_PING: begin
        f.id = ID_PING;
      end
      K_WAKE_ONE: begin
        f.id      = ID_BOOT;
        f.len     = LEN_WAKE;
        f.payload = {MAGIC_ZERO, MAGIC_ONE, h, l, WAKE_ONE_BYTE, 24'd0};
      end
      K_WAKE_TWO: begin
        f.id      = ID_BOOT;
        f.len     = LEN_WAKE;
        f.payload = {MAGIC_ZERO, MAGIC_ONE, h, l, WAKE_TWO_BYTE, 24'd0};
      end
      K_WAKE_THR: begin
        f.id      = ID_WAKE3;
        f.len     = LEN_WAKE3;
        f.payload = {MAGIC_ZERO, MAGIC_ONE, h, l, WAKE_THREE_BYTE, 8'd0, l, 8'd0};
      end
      K_LEN_ONE: begin
        f.id      = ID_SETUP;
        f.len     = LEN_FULL;
        f.payload = setup_payload(h, l, SEL_LEN_ONE, 8'd0, cfg.bus_len[0]);
      end
      K_LEN_TWO: begin
        f.id      = ID_SETUP;
        f.len     = LEN_FULL;
        f.payload = setup_payload(h, l, SEL_LEN_TWO, 8'd0, cfg.bus_len[1]);
      end
      K_LEN_THR: begin
        f.id      = ID_SETUP;
        f.len     = LEN_FULL;
        f.payload = setup_payload(h, l, SEL_LEN_THREE, 8'd0, cfg.bus_len[2]);
      end
      K_CYC_ONE: begin
        f.id      = ID_SETUP;
        f.len     = LEN_FULL;
        f.payload = setup_payload(h, l, SEL_CYC_ONE, cyc_hi(cfg.bus_cycle[0]),
                                  cfg.bus_cycle[0][7:0]);
      end
      K_CYC_TWO: begin
        f.id      = ID_SETUP;
        f.len     = LEN_FULL;
        f.payload = setup_payload(h, l, SEL_CYC_TWO, cyc_hi(cfg.bus_cycle[1]),
                                  cfg.bus_cycle[1][7:0]);
      end
      K_CYC_THR: begin
        f.id      = ID_SETUP;
        f.len     = LEN_FULL;
        f.payload = setup_payload(h, l, SEL_CYC_THREE, cyc_hi(cfg.bus_cycle[2]),
                                  cfg.bus_cycle[2][7:0]);
      end
      default: begin
        // finished marker
        f.present = 1'b0;
        f.fin     = 1'b1;
      end
    endcase
    return f;
  endfunction

endpackage

FILE: rtl/cmwr_in_if.sv
`timescale 1ns / 1ps

interface cmwr_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic        is_extended;
  logic [28:0] rx_identifier;
  logic [3:0]  rx_length;
  logic [7:0]  rx_byte_zero;
  logic [7:0]  rx_byte_one;
  logic [7:0]  rx_byte_two;
  logic [7:0]  rx_byte_three;

  modport source (
    output valid, command, is_extended, rx_identifier, rx_length,
           rx_byte_zero, rx_byte_one, rx_byte_two, rx_byte_three,
    input  ready
  );

  modport sink (
    input  valid, command, is_extended, rx_identifier, rx_length,
           rx_byte_zero, rx_byte_one, rx_byte_two, rx_byte_three,
    output ready
  );
endinterface

FILE: rtl/cmwr_out_if.sv
`timescale 1ns / 1ps

interface cmwr_out_if;
  logic        valid;
  logic        ready;
  logic        frame_present;
  logic [28:0] tx_identifier;
  logic [3:0]  tx_length;
  logic [63:0] tx_payload;
  logic        last_of_run;
  logic        finished;

  modport source (
    output valid, frame_present, tx_identifier, tx_length, tx_payload,
           last_of_run, finished,
    input  ready
  );

  modport sink (
    input  valid, frame_present, tx_identifier, tx_length, tx_payload,
           last_of_run, finished,
    output ready
  );
endinterface

FILE: rtl/cmwr_cfg_regs.sv
`timescale 1ns / 1ps

module cmwr_cfg_regs
  import cmwr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output cfg_t        cfg
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];
  assign cfg     = cfg_r;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r        <= '0;
      cfg_r.needed <= 8'd1;
    end else if (wr_en) begin
      case (reg_idx)
        REG_BUS_ONE_LENGTH:   cfg_r.bus_len[0]   <= pwdata[7:0];
        REG_BUS_TWO_LENGTH:   cfg_r.bus_len[1]   <= pwdata[7:0];
        REG_BUS_THREE_LENGTH: cfg_r.bus_len[2]   <= pwdata[7:0];
        REG_BUS_ONE_CYCLE:    cfg_r.bus_cycle[0] <= pwdata[9:0];
        REG_BUS_TWO_CYCLE:    cfg_r.bus_cycle[1] <= pwdata[9:0];
        REG_BUS_THREE_CYCLE:  cfg_r.bus_cycle[2] <= pwdata[9:0];
        REG_NEEDED_DEVICES:   cfg_r.needed       <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (reg_idx)
      REG_BUS_ONE_LENGTH:   prdata = {24'd0, cfg_r.bus_len[0]};
      REG_BUS_TWO_LENGTH:   prdata = {24'd0, cfg_r.bus_len[1]};
      REG_BUS_THREE_LENGTH: prdata = {24'd0, cfg_r.bus_len[2]};
      REG_BUS_ONE_CYCLE:    prdata = {22'd0, cfg_r.bus_cycle[0]};
      REG_BUS_TWO_CYCLE:    prdata = {22'd0, cfg_r.bus_cycle[1]};
      REG_BUS_THREE_CYCLE:  prdata = {22'd0, cfg_r.bus_cycle[2]};
      REG_NEEDED_DEVICES:   prdata = {24'd0, cfg_r.needed};
      default:              prdata = '0;
    endcase
  end

endmodule

FILE: rtl/cmwr_dev_table.sv
`timescale 1ns / 1ps

// Known-device table. Entries fill in order, so the fill count marks the
// valid ones. A search walks the filled entries one per cycle through a
// single registered read port and a single 16-bit comparator.
module cmwr_dev_table
  import cmwr_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  tbl_req_t req,
  output tbl_rsp_t rsp
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [15:0]   mem [DEPTH];
  logic [15:0]   key_r;
  logic [15:0]   rd_r;
  logic [CW-1:0] fill_r;
  logic [IW-1:0] idx_r;
  logic          busy_r;
  logic          rd_vld_r;
  logic          rd_last_r;
  logic          done_r;
  logic          hit_r;
  logic          last_issue;
  logic          has_room;
  logic          match;

  assign last_issue = ((CW'(idx_r) + CW'(1)) == fill_r);
  assign has_room   = (fill_r < CW'(DEPTH));
  assign match      = rd_vld_r && (rd_r == key_r);
  assign rsp.done   = done_r;
  assign rsp.hit    = hit_r;

  // Search sequencer and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      rd_vld_r <= 1'b0;
      done_r   <= 1'b0;
      fill_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.search) begin
        key_r    <= req.key;
        idx_r    <= '0;
        rd_vld_r <= 1'b0;
        if (fill_r == '0) begin
          done_r <= 1'b1;
          hit_r  <= 1'b0;
        end else begin
          busy_r <= 1'b1;
        end
      end else begin
        // issue stage
        rd_vld_r  <= busy_r;
        rd_last_r <= last_issue;
        if (busy_r) begin
          idx_r <= idx_r + IW'(1);
          if (last_issue) begin
            busy_r <= 1'b0;
          end
        end
        // compare stage
        if (match) begin
          done_r   <= 1'b1;
          hit_r    <= 1'b1;
          busy_r   <= 1'b0;
          rd_vld_r <= 1'b0;
        end else if (rd_vld_r && rd_last_r) begin
          done_r <= 1'b1;
          hit_r  <= 1'b0;
        end
      end
      if (req.store && has_room) begin
        fill_r <= fill_r + CW'(1);
      end
    end
  end

  // Storage: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (req.store && has_room) begin
      mem[fill_r[IW-1:0]] <= key_r;
    end
    rd_r <= mem[idx_r];
  end

endmodule

FILE: rtl/can_module_wakeup_responder_top.sv
`timescale 1ns / 1ps

// Channel  | Ports                       | Role
// ---------+-----------------------------+----------------------------------
// input    | in_if (valid/ready)         | start request or received frame
// result   | out_if (valid/ready)        | frames to send, finished marker
// config   | psel/penable/pwrite/paddr.. | APB writes, registers at 4*index
//
// An input is taken only while the control FSM is idle. A checked 0x31/0x37
// frame walks the device table, one entry per cycle.
// Results then leave one per cycle from the output register while out ready
// is high; up to seven per input. Reset clears the table fill count, device
// count and halt flag. A stalled output holds its register.
module can_module_wakeup_responder_top
  import cmwr_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  cmwr_in_if.sink          in_if,
  cmwr_out_if.source       out_if,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [4:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SRCH = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t     state_r;
  cfg_t       cfg;
  tbl_req_t   tbl_req;
  tbl_rsp_t   tbl_rsp;
  kind_mask_t mask_r;
  kind_mask_t sel_onehot;
  kind_mask_t setup_mask;
  logic [3:0] sel_kind;
  logic [7:0] h_r;
  logic [7:0] l_r;
  logic [7:0] count_r;
  logic [7:0] count_nxt;
  logic       halted_r;
  logic       is_wake_r;
  logic       in_acc;
  logic       frame_ok;
  logic       go_search;
  logic [7:0] cmd_byte;
  logic       fin_now;
  logic       out_load;
  logic       out_valid_r;
  frame_t     out_frame_r;
  logic       out_last_r;

  assign pready = 1'b1;

  cmwr_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  cmwr_dev_table #(
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (tbl_req),
    .rsp   (tbl_rsp)
  );

  // Input decode
  assign in_if.ready = (state_r == S_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;
  assign cmd_byte    = in_if.rx_identifier[23:16];
  assign frame_ok    = in_if.is_extended && (in_if.rx_length == LEN_FULL) &&
                       (in_if.rx_byte_zero == MAGIC_ZERO) &&
                       (in_if.rx_byte_one == MAGIC_ONE) &&
                       ((cmd_byte == CMD_WAKE) || (cmd_byte == CMD_CONFIG));
  assign go_search   = in_acc && !halted_r && in_if.command && frame_ok;

  assign tbl_req.search = go_search;
  assign tbl_req.key    = {in_if.rx_byte_two - KEY_OFFSET, in_if.rx_byte_three};
  assign tbl_req.store  = (state_r == S_SRCH) && tbl_rsp.done && !is_wake_r && !tbl_rsp.hit;

  // Device count after this frame
  assign count_nxt = (!tbl_rsp.hit && (count_r != 8'hFF)) ? count_r + 8'd1 : count_r;
  assign fin_now   = (count_nxt >= cfg.needed);

  // Setup frames for nonzero settings
  always_comb begin
    setup_mask                   = '0;
    setup_mask[K_LEN_ONE]        = (cfg.bus_len[0] != '0);
    setup_mask[K_LEN_TWO]        = (cfg.bus_len[1] != '0);
    setup_mask[K_LEN_THR]        = (cfg.bus_len[2] != '0);
    setup_mask[K_CYC_ONE]        = (cfg.bus_cycle[0] != '0);
    setup_mask[K_CYC_TWO]        = (cfg.bus_cycle[1] != '0);
    setup_mask[K_CYC_THR]        = (cfg.bus_cycle[2] != '0);
  end

  // Lowest pending kind goes next
  always_comb begin
    sel_kind   = K_FIN;
    sel_onehot = '0;
    for (int i = NUM_KINDS - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        sel_kind   = 4'(i);
        sel_onehot = kind_mask_t'(1) << i;
      end
    end
  end

  assign out_load = (state_r == S_EMIT) && (!out_valid_r || out_if.ready);

  // Control sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      halted_r <= 1'b0;
      count_r  <= '0;
      mask_r   <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            h_r       <= in_if.rx_byte_two;
            l_r       <= in_if.rx_byte_three;
            is_wake_r <= (cmd_byte == CMD_WAKE);
            if (!halted_r && !in_if.command) begin
              mask_r  <= '0;
              mask_r[K_BOOT] <= 1'b1;
              mask_r[K_PING] <= 1'b1;
              state_r <= S_EMIT;
            end else if (go_search) begin
              state_r <= S_SRCH;
            end
          end
        end
        S_SRCH: begin
          if (tbl_rsp.done) begin
            if (is_wake_r) begin
              if (tbl_rsp.hit) begin
                state_r <= S_IDLE;
              end else begin
                mask_r             <= '0;
                mask_r[K_WAKE_ONE] <= 1'b1;
                mask_r[K_WAKE_TWO] <= 1'b1;
                mask_r[K_WAKE_THR] <= 1'b1;
                mask_r[K_PING]     <= 1'b1;
                state_r            <= S_EMIT;
              end
            end else begin
              count_r <= count_nxt;
              mask_r  <= (tbl_rsp.hit ? kind_mask_t'(0) : setup_mask) |
                         (fin_now ? (kind_mask_t'(1) << K_FIN) : kind_mask_t'(0));
              if (fin_now) begin
                halted_r <= 1'b1;
              end
              if (fin_now || (!tbl_rsp.hit && (setup_mask != '0))) begin
                state_r <= S_EMIT;
              end else begin
                state_r <= S_IDLE;
              end
            end
          end
        end
        S_EMIT: begin
          if (out_load) begin
            mask_r <= mask_r & ~sel_onehot;
            if ((mask_r & ~sel_onehot) == '0) begin
              state_r <= S_IDLE;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_frame_r <= build_frame(sel_kind, h_r, l_r, cfg);
      out_last_r  <= ((mask_r & ~sel_onehot) == '0);
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.frame_present = out_frame_r.present;
  assign out_if.tx_identifier = out_frame_r.id;
  assign out_if.tx_length     = out_frame_r.len;
  assign out_if.tx_payload    = out_frame_r.payload;
  assign out_if.last_of_run   = out_last_r;
  assign out_if.finished      = out_frame_r.fin;

endmodule

FILE: dv/tb_can_module_wakeup_responder_top.sv
`timescale 1ns / 1ps

module tb_can_module_wakeup_responder_top;
  import cmwr_pkg::*;

  localparam int TABLE_DEPTH = 16;
  localparam int SETTLE_CYCLES = TABLE_DEPTH + 8;
  // keep the device count well clear of the finish threshold until the last test
  localparam int COUNT_CEILING = 200;

  // input item kinds and a command byte the block must ignore
  localparam logic       ITEM_START = 1'b0;
  localparam logic       ITEM_FRAME = 1'b1;
  localparam logic [7:0] CMD_OTHER  = 8'h30;

  localparam logic [2:0][7:0] LEN_SEL = {SEL_LEN_THREE, SEL_LEN_TWO, SEL_LEN_ONE};
  localparam logic [2:0][7:0] CYC_SEL = {SEL_CYC_THREE, SEL_CYC_TWO, SEL_CYC_ONE};

  typedef struct packed {
    logic        command;
    logic        is_extended;
    logic [28:0] ident;
    logic [3:0]  len;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  h;
    logic [7:0]  l;
  } rx_item_t;

  typedef struct packed {
    logic        present;
    logic [28:0] ident;
    logic [3:0]  len;
    logic [63:0] payload;
    logic        last;
    logic        fin;
  } tx_frame_t;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  cmwr_in_if  rx_ch ();
  cmwr_out_if tx_ch ();

  can_module_wakeup_responder_top #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (rx_ch),
    .out_if (tx_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // shadow of the block: device table, counters, registers
  logic [15:0] dev_keys [TABLE_DEPTH];
  logic        dev_valid [TABLE_DEPTH];
  int          dev_count;
  bit          halted_q;
  cfg_t        shadow_cfg;

  tx_frame_t   pending_frames [$];
  logic [7:0]  pool_h [24];
  logic [7:0]  pool_l [24];

  int idle_pct;
  int mismatches;
  int items_sent;
  int results_seen;
  int reg_writes;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d results outstanding", pending_frames.size());
    $display("CHECK FAILED");
    $finish;
  end

  //--------------------------------------------------------------------------
  // Shadow model
  //--------------------------------------------------------------------------

  function automatic logic [7:0] rand_byte();
    logic [31:0] r;
    r = $urandom;
    return r[7:0];
  endfunction

  function automatic logic [15:0] device_key(input logic [7:0] h, input logic [7:0] l);
    logic [7:0] hk;
    hk = h - KEY_OFFSET;
    return {hk, l};
  endfunction

  function automatic bit key_known(input logic [15:0] key);
    int i;
    for (i = 0; i < TABLE_DEPTH; i++) begin
      if (dev_valid[i] && dev_keys[i] == key) return 1'b1;
    end
    return 1'b0;
  endfunction

  // first free slot; a full table drops the key
  function automatic void store_key(input logic [15:0] key);
    int i;
    for (i = 0; i < TABLE_DEPTH; i++) begin
      if (!dev_valid[i]) begin
        dev_valid[i] = 1'b1;
        dev_keys[i]  = key;
        return;
      end
    end
  endfunction

  function automatic void push_frame(input logic present, input logic [28:0] ident,
                                     input logic [3:0] len, input logic [63:0] payload,
                                     input logic fin);
    tx_frame_t f;
    f.present = present;
    f.ident   = ident;
    f.len     = len;
    f.payload = payload;
    f.last    = 1'b0;
    f.fin     = fin;
    pending_frames.push_back(f);
  endfunction

  // expected frames for one accepted transaction; returns how many
  function automatic int predict_responses(input rx_item_t it);
    int         first;
    int         k;
    int         tail;
    logic [7:0] cmd;
    logic [15:0] key;
    bit         good;
    first = pending_frames.size();
    if (halted_q) return 0;
    if (it.command == ITEM_START) begin
      push_frame(1'b1, ID_BOOT, LEN_NONE, 64'd0, 1'b0);
      push_frame(1'b1, ID_PING, LEN_NONE, 64'd0, 1'b0);
    end else if (it.is_extended) begin
      cmd  = it.ident[23:16];
      key  = device_key(it.h, it.l);
      good = (it.len == LEN_FULL) && (it.b0 == MAGIC_ZERO) && (it.b1 == MAGIC_ONE);
      if (good && cmd == CMD_WAKE && !key_known(key)) begin
        push_frame(1'b1, ID_BOOT, LEN_WAKE,
                   {MAGIC_ZERO, MAGIC_ONE, it.h, it.l, WAKE_ONE_BYTE, 24'd0}, 1'b0);
        push_frame(1'b1, ID_BOOT, LEN_WAKE,
                   {MAGIC_ZERO, MAGIC_ONE, it.h, it.l, WAKE_TWO_BYTE, 24'd0}, 1'b0);
        push_frame(1'b1, ID_WAKE3, LEN_WAKE3,
                   {MAGIC_ZERO, MAGIC_ONE, it.h, it.l, WAKE_THREE_BYTE, 8'd0, it.l, 8'd0},
                   1'b0);
        push_frame(1'b1, ID_PING, LEN_NONE, 64'd0, 1'b0);
      end else if (good && cmd == CMD_CONFIG) begin
        if (!key_known(key)) begin
          store_key(key);
          if (dev_count < 255) dev_count++;
          for (k = 0; k < 3; k++) begin
            if (shadow_cfg.bus_len[k] != 8'd0)
              push_frame(1'b1, ID_SETUP, LEN_FULL,
                         {MAGIC_ZERO, MAGIC_ONE, it.h, it.l, SETUP_BYTE, LEN_SEL[k], 8'd0,
                          shadow_cfg.bus_len[k]}, 1'b0);
          end
          for (k = 0; k < 3; k++) begin
            if (shadow_cfg.bus_cycle[k] != 10'd0)
              push_frame(1'b1, ID_SETUP, LEN_FULL,
                         {MAGIC_ZERO, MAGIC_ONE, it.h, it.l, SETUP_BYTE, CYC_SEL[k],
                          6'd0, shadow_cfg.bus_cycle[k]}, 1'b0);
          end
        end
        // finish test runs for known devices too
        if (dev_count >= int'(shadow_cfg.needed)) begin
          push_frame(1'b0, 29'd0, LEN_NONE, 64'd0, 1'b1);
          halted_q = 1'b1;
        end
      end
    end
    if (pending_frames.size() > first) begin
      tail = pending_frames.size() - 1;
      pending_frames[tail].last = 1'b1;
    end
    return pending_frames.size() - first;
  endfunction

  //--------------------------------------------------------------------------
  // Result checking
  //--------------------------------------------------------------------------

  task automatic compare_field(input string fname, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", fname, want, got);
      mismatches++;
    end
  endtask

  initial begin
    tx_frame_t exp;
    tx_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && tx_ch.valid && tx_ch.ready) begin
        results_seen++;
        if (pending_frames.size() == 0) begin
          $error("result transaction with nothing expected: id 0x%0h", tx_ch.tx_identifier);
          mismatches++;
        end else begin
          exp = pending_frames.pop_front();
          compare_field("frame_present", 64'(exp.present), 64'(tx_ch.frame_present));
          compare_field("tx_identifier", 64'(exp.ident), 64'(tx_ch.tx_identifier));
          compare_field("tx_length", 64'(exp.len), 64'(tx_ch.tx_length));
          compare_field("tx_payload", exp.payload, tx_ch.tx_payload);
          compare_field("last_of_run", 64'(exp.last), 64'(tx_ch.last_of_run));
          compare_field("finished", 64'(exp.fin), 64'(tx_ch.finished));
        end
      end
      tx_ch.ready <= ($urandom_range(0, 99) >= idle_pct);
    end
  end

  //--------------------------------------------------------------------------
  // Drivers
  //--------------------------------------------------------------------------

  task automatic send_item(input rx_item_t it, output int produced);
    while ($urandom_range(0, 99) < idle_pct) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk);
    end
    rx_ch.valid         <= 1'b1;
    rx_ch.command       <= it.command;
    rx_ch.is_extended   <= it.is_extended;
    rx_ch.rx_identifier <= it.ident;
    rx_ch.rx_length     <= it.len;
    rx_ch.rx_byte_zero  <= it.b0;
    rx_ch.rx_byte_one   <= it.b1;
    rx_ch.rx_byte_two   <= it.h;
    rx_ch.rx_byte_three <= it.l;
    do begin
      @(posedge clk);
    end while (!rx_ch.ready);
    items_sent++;
    produced = predict_responses(it);
  endtask

  task automatic wait_results_drained();
    rx_ch.valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (pending_frames.size() != 0);
  endtask

  // block idle: all results in, plus time for a table walk that yields nothing
  task automatic drain_and_settle();
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(posedge clk);
    end while (!pready);
    reg_writes++;
    case (idx)
      REG_BUS_ONE_LENGTH:   shadow_cfg.bus_len[0]   = val[7:0];
      REG_BUS_TWO_LENGTH:   shadow_cfg.bus_len[1]   = val[7:0];
      REG_BUS_THREE_LENGTH: shadow_cfg.bus_len[2]   = val[7:0];
      REG_BUS_ONE_CYCLE:    shadow_cfg.bus_cycle[0] = val[9:0];
      REG_BUS_TWO_CYCLE:    shadow_cfg.bus_cycle[1] = val[9:0];
      REG_BUS_THREE_CYCLE:  shadow_cfg.bus_cycle[2] = val[9:0];
      REG_NEEDED_DEVICES:   shadow_cfg.needed       = val[7:0];
      default: ;
    endcase
  endtask

  task automatic program_registers(input cfg_t c);
    write_reg(REG_BUS_ONE_LENGTH, {24'd0, c.bus_len[0]});
    write_reg(REG_BUS_TWO_LENGTH, {24'd0, c.bus_len[1]});
    write_reg(REG_BUS_THREE_LENGTH, {24'd0, c.bus_len[2]});
    write_reg(REG_BUS_ONE_CYCLE, {22'd0, c.bus_cycle[0]});
    write_reg(REG_BUS_TWO_CYCLE, {22'd0, c.bus_cycle[1]});
    write_reg(REG_BUS_THREE_CYCLE, {22'd0, c.bus_cycle[2]});
    write_reg(REG_NEEDED_DEVICES, {24'd0, c.needed});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  //--------------------------------------------------------------------------
  // Item builders
  //--------------------------------------------------------------------------

  function automatic rx_item_t frame_item(input logic [7:0] cmd, input logic [7:0] h,
                                          input logic [7:0] l);
    rx_item_t    it;
    logic [31:0] r;
    r                = $urandom;
    it.command       = ITEM_FRAME;
    it.is_extended   = 1'b1;
    it.ident         = r[28:0];
    it.ident[23:16]  = cmd;
    it.len           = LEN_FULL;
    it.b0            = MAGIC_ZERO;
    it.b1            = MAGIC_ONE;
    it.h             = h;
    it.l             = l;
    return it;
  endfunction

  function automatic rx_item_t random_item();
    rx_item_t    it;
    logic [31:0] r0;
    logic [31:0] r1;
    logic [31:0] r2;
    logic [7:0]  cmd;
    logic [7:0]  h;
    logic [7:0]  l;
    logic [15:0] key;
    int          pick;
    int          k;
    r0   = $urandom;
    r1   = $urandom;
    r2   = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      // start requests and raw noise
      it.command     = (pick < 10) ? ITEM_START : ITEM_FRAME;
      it.is_extended = r0[30];
      it.ident       = r0[28:0];
      it.len         = r1[3:0];
      it.b0          = r1[15:8];
      it.b1          = r1[23:16];
      it.h           = r1[31:24];
      it.l           = r2[7:0];
      return it;
    end
    cmd = r0[31] ? CMD_CONFIG : CMD_WAKE;
    if ($urandom_range(0, 99) < 70) begin
      k = $urandom_range(0, 23);
      h = pool_h[k];
      l = pool_l[k];
    end else begin
      h = r2[15:8];
      l = r2[23:16];
    end
    key = device_key(h, l);
    // past the ceiling only devices already in the table may configure
    if (cmd == CMD_CONFIG && dev_count >= COUNT_CEILING && !key_known(key)) begin
      k = $urandom_range(0, TABLE_DEPTH - 1);
      h = dev_keys[k][15:8] + KEY_OFFSET;
      l = dev_keys[k][7:0];
    end
    it = frame_item(cmd, h, l);
    if (pick < 32) begin
      // broken sequence: one check fails
      case ($urandom_range(0, 4))
        0: it.is_extended = 1'b0;
        1: begin
          it.len = r1[3:0];
          if (it.len == LEN_FULL) it.len = 4'd15;
        end
        2: it.b0 = MAGIC_ZERO ^ (r1[7:0] | 8'h01);
        3: it.b1 = MAGIC_ONE ^ (r1[15:8] | 8'h80);
        default: begin
          it.ident[23:16] = r1[23:16];
          if (it.ident[23:16] == CMD_WAKE || it.ident[23:16] == CMD_CONFIG)
            it.ident[23:16] = CMD_OTHER;
        end
      endcase
    end
    return it;
  endfunction

  //--------------------------------------------------------------------------
  // Tests
  //--------------------------------------------------------------------------

  // reset settings: start requests, wake sequences, rejected frames
  task automatic test_start_and_wake();
    rx_item_t it;
    int       n;
    it         = '0;
    it.command = ITEM_START;
    send_item(it, n);
    it         = '1;
    it.command = ITEM_START;
    send_item(it, n);
    it              = frame_item(CMD_WAKE, 8'h00, 8'h00);
    it.ident        = '0;
    it.ident[23:16] = CMD_WAKE;
    send_item(it, n);
    it              = frame_item(CMD_WAKE, 8'hFF, 8'hFF);
    it.ident        = '1;
    it.ident[23:16] = CMD_WAKE;
    send_item(it, n);
    // device key of zero
    send_item(frame_item(CMD_WAKE, KEY_OFFSET, 8'h00), n);
    it             = frame_item(CMD_WAKE, 8'h12, 8'h34);
    it.is_extended = 1'b0;
    send_item(it, n);
    it     = frame_item(CMD_WAKE, 8'h12, 8'h34);
    it.len = 4'd15;
    send_item(it, n);
    it.len = 4'd0;
    send_item(it, n);
    it    = frame_item(CMD_WAKE, 8'h12, 8'h34);
    it.b0 = 8'h00;
    send_item(it, n);
    it    = frame_item(CMD_WAKE, 8'h12, 8'h34);
    it.b1 = 8'hFF;
    send_item(it, n);
    it              = frame_item(CMD_WAKE, 8'h12, 8'h34);
    it.ident[23:16] = CMD_OTHER;
    send_item(it, n);
  endtask

  // setup frames for all, some and none of the settings
  task automatic test_setup_frames();
    cfg_t c;
    int   n;
    drain_and_settle();
    c              = '0;
    c.bus_len[0]   = 8'd255;
    c.bus_len[1]   = 8'd255;
    c.bus_len[2]   = 8'd255;
    c.bus_cycle[0] = 10'd1000;
    c.bus_cycle[1] = 10'd1000;
    c.bus_cycle[2] = 10'd1000;
    c.needed       = 8'd255;
    program_registers(c);
    send_item(frame_item(CMD_CONFIG, 8'hFF, 8'h00), n);
    // the same device again, on both commands
    send_item(frame_item(CMD_CONFIG, 8'hFF, 8'h00), n);
    send_item(frame_item(CMD_WAKE, 8'hFF, 8'h00), n);
    drain_and_settle();
    c              = '0;
    c.bus_len[0]   = 8'd1;
    c.bus_len[2]   = 8'd128;
    c.bus_cycle[1] = 10'd1;
    c.bus_cycle[2] = 10'h300;
    c.needed       = 8'd255;
    program_registers(c);
    send_item(frame_item(CMD_CONFIG, 8'h00, 8'hFF), n);
    drain_and_settle();
    // nothing to set up: device stored silently
    c        = '0;
    c.needed = 8'd255;
    program_registers(c);
    send_item(frame_item(CMD_CONFIG, KEY_OFFSET, 8'h01), n);
    send_item(frame_item(CMD_WAKE, KEY_OFFSET, 8'h01), n);
  endtask

  // fill the table, then devices beyond it are counted but not stored
  task automatic test_table_full();
    cfg_t       c;
    int         n;
    logic [7:0] h;
    logic [7:0] l;
    drain_and_settle();
    c              = '0;
    c.bus_len[1]   = 8'd7;
    c.bus_cycle[2] = 10'h2AA;
    c.needed       = 8'd255;
    program_registers(c);
    repeat (TABLE_DEPTH + 3) begin
      do begin
        h = rand_byte();
        l = rand_byte();
      end while (key_known(device_key(h, l)));
      send_item(frame_item(CMD_CONFIG, h, l), n);
    end
    // last one never made it into the table: configured once more
    send_item(frame_item(CMD_CONFIG, h, l), n);
  endtask

  task automatic test_random_traffic();
    cfg_t c;
    int   n;
    int   ph;
    int   k;
    int   attempts;
    rx_item_t it;
    for (k = 0; k < 24; k++) begin
      if (k < 8) begin
        n          = $urandom_range(0, TABLE_DEPTH - 1);
        pool_h[k]  = dev_keys[n][15:8] + KEY_OFFSET;
        pool_l[k]  = dev_keys[n][7:0];
      end else begin
        pool_h[k] = rand_byte();
        pool_l[k] = rand_byte();
      end
    end
    attempts = 0;
    for (ph = 0; ph < 5; ph++) begin
      c        = '0;
      c.needed = 8'd255;
      for (k = 0; k < 3; k++) begin
        case (ph)
          0: begin
            c.bus_len[k]   = 8'd255;
            c.bus_cycle[k] = 10'd1000;
          end
          1: ;
          4: begin
            c.bus_len[k]   = 8'd1;
            c.bus_cycle[k] = 10'd1;
          end
          default: begin
            if ($urandom_range(0, 9) >= 3) c.bus_len[k] = rand_byte() | 8'd1;
            if ($urandom_range(0, 9) >= 3) c.bus_cycle[k] = 10'($urandom_range(1, 1000));
          end
        endcase
      end
      // phase three runs with neither side idling
      idle_pct = (ph == 3) ? 0 : 6;
      drain_and_settle();
      program_registers(c);
      while (attempts < 94 * (ph + 1)) begin
        it = random_item();
        send_item(it, n);
        attempts++;
        if ($urandom_range(0, 99) < 2) wait_results_drained();
      end
    end
    idle_pct = 6;
  endtask

  // reach the needed count on a known device, then the block stays silent
  task automatic test_finish_and_halt();
    cfg_t c;
    int   n;
    drain_and_settle();
    c        = shadow_cfg;
    c.needed = 8'(dev_count);
    program_registers(c);
    send_item(frame_item(CMD_CONFIG, dev_keys[0][15:8] + KEY_OFFSET, dev_keys[0][7:0]), n);
    send_item('0, n);
    send_item(frame_item(CMD_WAKE, rand_byte(), rand_byte()), n);
    send_item(frame_item(CMD_CONFIG, rand_byte(), rand_byte()), n);
    drain_and_settle();
  endtask

  //--------------------------------------------------------------------------
  // Sequence
  //--------------------------------------------------------------------------

  initial begin
    int i;
    rst_n               <= 1'b0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    rx_ch.valid         <= 1'b0;
    rx_ch.command       <= 1'b0;
    rx_ch.is_extended   <= 1'b0;
    rx_ch.rx_identifier <= '0;
    rx_ch.rx_length     <= '0;
    rx_ch.rx_byte_zero  <= '0;
    rx_ch.rx_byte_one   <= '0;
    rx_ch.rx_byte_two   <= '0;
    rx_ch.rx_byte_three <= '0;
    for (i = 0; i < TABLE_DEPTH; i++) begin
      dev_keys[i]  = '0;
      dev_valid[i] = 1'b0;
    end
    dev_count         = 0;
    halted_q          = 1'b0;
    shadow_cfg        = '0;
    shadow_cfg.needed = 8'd1;
    idle_pct          = 6;
    mismatches        = 0;
    items_sent        = 0;
    results_seen      = 0;
    reg_writes        = 0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_start_and_wake();
    test_setup_frames();
    test_table_full();
    test_random_traffic();
    test_finish_and_halt();

    $display("Covered %0d input and %0d result transactions, %0d register writes",
             items_sent, results_seen, reg_writes);
    $display("Devices counted %0d over a %0d-entry table, run ended in the halted state",
             dev_count, TABLE_DEPTH);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
